/* rtl/rwvg_pkg.sv */
// Shared constants, codes and types for the RSSI window variance grader.
package rwvg_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int SAMPLE_W     = 10;
  localparam int SUM_W        = SAMPLE_W + ADDR_W;
  localparam int SQ_W         = 2 * SAMPLE_W - 1;
  localparam int SUMSQ_W      = SQ_W + ADDR_W;
  localparam int VAR_W        = 19;
  localparam int LIMIT_W      = 18;
  localparam int FILL_W       = ADDR_W + 1;

  localparam int DIFF_W       = VAR_W + 2;
  localparam logic signed [DIFF_W-1:0] VAR_MAX = DIFF_W'(262143);
  localparam logic signed [DIFF_W-1:0] VAR_MIN = -DIFF_W'(262144);

  localparam logic [1:0] QUAL_EXCELLENT = 2'd0;
  localparam logic [1:0] QUAL_GOOD      = 2'd1;
  localparam logic [1:0] QUAL_FAIR      = 2'd2;
  localparam logic [1:0] QUAL_POOR      = 2'd3;

  localparam logic [1:0] REG_EXCELLENT = 2'd0;
  localparam logic [1:0] REG_GOOD      = 2'd1;
  localparam logic [1:0] REG_FAIR      = 2'd2;

  localparam logic [LIMIT_W-1:0] EXCELLENT_RST = LIMIT_W'(9);
  localparam logic [LIMIT_W-1:0] GOOD_RST      = LIMIT_W'(36);
  localparam logic [LIMIT_W-1:0] FAIR_RST      = LIMIT_W'(100);

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SUMSQ_W-1:0]      sumsq;
  } win_stats_t;

endpackage

/* rtl/rssi_window_variance_grader_unit.sv */
// Top level of the RSSI window variance grader.
//
// Slave stream s_*: one signed 10-bit dBm sample per transaction.
// Master stream m_*: one graded result per sample; tdata carries quality and
// the window variance, tuser flags that the window is still filling.
// Config port: cfg_we writes limit cfg_index (0 excellent, 1 good, 2 fair);
// other indexes are ignored. Write only while the block is idle.
//
// While filling, the result is registered with the input transaction and put
// out from the emit state. Once full, the ring memory is walked one entry per
// cycle through a single 10x10 multiply-accumulate; the 8 reads, the read/square
// pipe and the mean-square, variance and grading stages then lead to the emit
// state, which puts the result out.
// One sample is processed at a time; s_tready is high whenever the block is
// idle, even while a result waits on m_tready. With the output stalled the
// next result waits in the output stage, holding s_tready low, until it drains.
//
// Reset (rst, synchronous) empties the window and restores the default
// limits 9, 36 and 100. No memory clearing pass is needed: results are
// forced to poor until all eight entries have been written.
module rssi_window_variance_grader_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] rssi_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [1:0] quality, [20:2] variance
  output logic        m_tuser,   // [0] filling
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [rwvg_pkg::LIMIT_W-1:0] cfg_data
);
  import rwvg_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_MEAN  = 3'd2;
  localparam logic [2:0] ST_VAR   = 3'd3;
  localparam logic [2:0] ST_GRADE = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]           state;
  logic [ADDR_W-1:0]    wslot;
  logic [FILL_W-1:0]    fill_count;
  logic [FILL_W-1:0]    fill_next;
  logic [LIMIT_W-1:0]   excellent_limit;
  logic [LIMIT_W-1:0]   good_limit;
  logic [LIMIT_W-1:0]   fair_limit;
  logic                 in_xfer;
  logic                 win_start;
  logic                 win_done;
  win_stats_t           stats;

  logic signed [SAMPLE_W-1:0]   mean;
  logic signed [2*SAMPLE_W-1:0] mean_prod;
  logic [SQ_W-1:0]              msq;
  logic [SQ_W-1:0]              sq8;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [VAR_W-1:0]      var_sat;
  logic [1:0]                   res_quality;
  logic signed [VAR_W-1:0]      res_variance;
  logic                         res_filling;
  logic [1:0]                   grade;
  logic                         out_free;

  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign fill_next = (fill_count == FILL_W'(WINDOW_DEPTH)) ? fill_count
                                                            : fill_count + 1'b1;
  assign win_start = in_xfer && (fill_next == FILL_W'(WINDOW_DEPTH));
  assign out_free  = !m_tvalid || m_tready;

  assign mean      = SAMPLE_W'(stats.sum >>> ADDR_W);
  assign mean_prod = mean * mean;
  assign diff      = $signed({2'b00, sq8}) - $signed({2'b00, msq});

  always_comb begin
    if ($signed({var_sat[VAR_W-1], var_sat}) < $signed({2'b00, excellent_limit})) begin
      grade = QUAL_EXCELLENT;
    end else if ($signed({var_sat[VAR_W-1], var_sat}) < $signed({2'b00, good_limit})) begin
      grade = QUAL_GOOD;
    end else if ($signed({var_sat[VAR_W-1], var_sat}) < $signed({2'b00, fair_limit})) begin
      grade = QUAL_FAIR;
    end else begin
      grade = QUAL_POOR;
    end
  end

  rwvg_window u_window (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_xfer),
    .wr_addr (wslot),
    .wr_data (s_tdata[SAMPLE_W-1:0]),
    .start   (win_start),
    .done    (win_done),
    .stats   (stats)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_MEAN) begin
      msq <= mean_prod[SQ_W-1:0];
      sq8 <= stats.sumsq[SUMSQ_W-1:ADDR_W];
    end
    if (state == ST_VAR) begin
      if (diff > VAR_MAX) begin
        var_sat <= VAR_MAX[VAR_W-1:0];
      end else if (diff < VAR_MIN) begin
        var_sat <= VAR_MIN[VAR_W-1:0];
      end else begin
        var_sat <= diff[VAR_W-1:0];
      end
    end
    if (in_xfer && !win_start) begin
      res_quality  <= QUAL_POOR;
      res_variance <= '0;
      res_filling  <= 1'b1;
    end else if (state == ST_GRADE) begin
      res_quality  <= grade;
      res_variance <= var_sat;
      res_filling  <= 1'b0;
    end
    if ((state == ST_EMIT) && out_free) begin
      m_tdata <= {3'b000, res_variance, res_quality};
      m_tuser <= res_filling;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      wslot           <= '0;
      fill_count      <= '0;
      m_tvalid        <= 1'b0;
      excellent_limit <= EXCELLENT_RST;
      good_limit      <= GOOD_RST;
      fair_limit      <= FAIR_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_EXCELLENT: excellent_limit <= cfg_data;
          REG_GOOD:      good_limit      <= cfg_data;
          REG_FAIR:      fair_limit      <= cfg_data;
          default: ;
        endcase
      end
      if (m_tready && !((state == ST_EMIT) && out_free)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            wslot      <= (wslot == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wslot + 1'b1;
            fill_count <= fill_next;
            state      <= win_start ? ST_WALK : ST_EMIT;
          end
        end
        ST_WALK: begin
          if (win_done) begin
            state <= ST_MEAN;
          end
        end
        ST_MEAN:  state <= ST_VAR;
        ST_VAR:   state <= ST_GRADE;
        ST_GRADE: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  a_filling_poor: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[1:0] == QUAL_POOR && m_tdata[20:2] == '0))
    else $error("filling result not poor with zero variance");

  a_done_in_walk: assert property (@(posedge clk) disable iff (rst)
    win_done |-> (state == ST_WALK))
    else $error("window walk finished outside walk state");

  a_walk_after_full: assert property (@(posedge clk) disable iff (rst)
    win_start |=> (fill_count == FILL_W'(WINDOW_DEPTH)))
    else $error("walk started before window full");
`endif

endmodule

/* rtl/rwvg_window.sv */
// Sample ring memory and the multiply-accumulate walk over its entries.
module rwvg_window (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [rwvg_pkg::ADDR_W-1:0]    wr_addr,
  input  logic signed [rwvg_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                           start,
  output logic                           done,
  output rwvg_pkg::win_stats_t           stats
);
  import rwvg_pkg::*;

  logic signed [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] d_reg;
  logic [SQ_W-1:0]            sq;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic [ADDR_W-1:0]          rd_cnt;
  logic [ADDR_W-1:0]          acc_cnt;
  logic                       issuing;
  logic                       rd_vld;
  logic                       sq_vld;

  assign prod = rd_data * rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    if (issuing) begin
      rd_data <= ring[rd_cnt];
    end
    if (rd_vld) begin
      sq    <= prod[SQ_W-1:0];
      d_reg <= rd_data;
    end
    if (start) begin
      stats.sum   <= '0;
      stats.sumsq <= '0;
    end else if (sq_vld) begin
      stats.sum   <= stats.sum + SUM_W'(d_reg);
      stats.sumsq <= stats.sumsq + SUMSQ_W'(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_cnt  <= '0;
      rd_vld  <= 1'b0;
      sq_vld  <= 1'b0;
      acc_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done   <= !start && sq_vld && (acc_cnt == ADDR_W'(WINDOW_DEPTH - 1));
      rd_vld <= issuing;
      sq_vld <= rd_vld;
      if (start) begin
        issuing <= 1'b1;
        rd_cnt  <= '0;
        acc_cnt <= '0;
      end else begin
        if (issuing) begin
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == ADDR_W'(WINDOW_DEPTH - 1)) begin
            issuing <= 1'b0;
          end
        end
        if (sq_vld) begin
          acc_cnt <= acc_cnt + 1'b1;
        end
      end
    end
  end

endmodule
